@@ hw/rtl/dqr_pkg.sv @@
// Shared types and constants for the double-ended queue with reverse.
`timescale 1ns / 1ps
package dqr_pkg;

	// Field widths
	localparam int VALUE_W    = 32;
	localparam int KIND_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int OCC_W      = 5;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;
	localparam int DEPTH_DEF  = 16;

	// Request kinds
	typedef enum logic [KIND_W-1:0] {
		K_PUSH_BACK  = 3'd0,
		K_PUSH_FRONT = 3'd1,
		K_POP_BACK   = 3'd2,
		K_POP_FRONT  = 3'd3,
		K_REVERSE    = 3'd4,
		K_DUMP       = 3'd5
	} kind_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Command broadcast to every cell of the row
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_LOW,
		CELL_PUSH_HIGH,
		CELL_POP_LOW,
		CELL_ROT_LEFT,
		CELL_ROT_RIGHT
	} cell_op_t;

	typedef struct packed {
		cell_op_t             op;
		logic [VALUE_W-1:0]   value;
	} cell_ctrl_t;

	// Controller states
	typedef enum logic {
		S_OPS,
		S_DUMP
	} state_t;

endpackage

@@ hw/rtl/dqr_cell.sv @@
// One storage cell of the row: holds one element and trades it with its neighbors.
`timescale 1ns / 1ps
module dqr_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dqr_pkg::cell_ctrl_t         ctrl,
	input  logic [CW-1:0]               count,
	input  logic [dqr_pkg::VALUE_W-1:0] left,
	input  logic [dqr_pkg::VALUE_W-1:0] right,
	input  logic [dqr_pkg::VALUE_W-1:0] tail_in,
	output logic [dqr_pkg::VALUE_W-1:0] data,
	output logic [dqr_pkg::VALUE_W-1:0] tail_out
);
	import dqr_pkg::*;

	localparam logic [CW-1:0] AT     = CW'(IDX);
	localparam logic [CW-1:0] AT_P1  = CW'(IDX + 1);

	logic [VALUE_W-1:0] data_q;
	logic [VALUE_W-1:0] data_d;
	logic               is_tail;
	logic               in_use;

	assign is_tail = (count == AT_P1);
	assign in_use  = (AT < count);

	// Pick the next content from the broadcast command
	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			CELL_PUSH_LOW: begin
				if (IDX == 0) data_d = ctrl.value;
				else data_d = left;
			end
			CELL_PUSH_HIGH: begin
				if (count == AT) data_d = ctrl.value;
			end
			CELL_POP_LOW: data_d = right;
			CELL_ROT_LEFT: begin
				if (is_tail) data_d = ctrl.value;
				else if (in_use) data_d = right;
			end
			CELL_ROT_RIGHT: begin
				if (IDX == 0) data_d = ctrl.value;
				else if (in_use) data_d = left;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) data_q <= '0;
		else data_q <= data_d;
	end

	// Pass the tail element down the row
	assign data     = data_q;
	assign tail_out = tail_in | (is_tail ? data_q : '0);

endmodule

@@ hw/rtl/deque_with_reverse.sv @@
// Top level of the double-ended queue with reverse: controller, cell row and result register.
// Each request is one push, pop, reverse or dump on a queue of up to DEPTH signed
// 32-bit words, held in a row of cells with the logical front at either end of
// the row depending on a reverse flag. Push, pop, reverse and unused kinds each
// give one result; they follow back to back as long as results are taken. A
// dump is accepted without a result and then gives one result per stored
// element while results are taken (an empty queue gives one empty result), because
// the row rotates by one cell per emitted element; no request is taken until the
// last element is in the result register. Results wait in a single output register
// that can be refilled in the cycle it is taken. After reset the queue holds one
// zero element.
`timescale 1ns / 1ps
module deque_with_reverse #(
	parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [dqr_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] value
	input  logic [dqr_pkg::KIND_W-1:0]     s_axis_tuser,  // [2:0] kind
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [dqr_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] element, [36:32] occupancy
	output logic [dqr_pkg::STATUS_W-1:0]   m_axis_tuser,  // [1:0] status
	output logic                           m_axis_tlast
);
	import dqr_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       dump_left_q;
	logic                rev_q, rev_d;
	cell_ctrl_t          ctrl;
	kind_t               kind;
	logic                s_fire;
	logic                out_free;
	logic                dump_start;
	logic                dump_step;
	logic                push_low;
	logic                pop_low;

	logic                res_load;
	status_t             res_status;
	logic [VALUE_W-1:0]  res_element;
	logic                res_last;
	logic [CW-1:0]       res_count;

	logic                m_valid_q;
	status_t             m_status_q;
	logic [VALUE_W-1:0]  m_element_q;
	logic [OCC_W-1:0]    m_occ_q;
	logic                m_last_q;

	logic [VALUE_W-1:0]  cell_data [DEPTH];
	logic [VALUE_W-1:0]  tail_c    [DEPTH+1];

	assign kind     = kind_t'(s_axis_tuser);
	assign out_free = !m_valid_q || m_axis_tready;
	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign push_low = (kind == K_PUSH_BACK) ? rev_q : !rev_q;
	assign pop_low  = (kind == K_POP_BACK) ? rev_q : !rev_q;

	// Advance the controller
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_OPS: begin
				if (s_fire && kind == K_DUMP && count_q != '0) state_d = S_DUMP;
			end
			S_DUMP: begin
				if (out_free && dump_left_q == ONE_CNT) state_d = S_OPS;
			end
			default: state_d = S_OPS;
		endcase
	end

	// Decode the request into a cell command and a result
	always_comb begin
		s_axis_tready = 1'b0;
		ctrl.op       = CELL_HOLD;
		ctrl.value    = s_axis_tdata[VALUE_W-1:0];
		count_d       = count_q;
		rev_d         = rev_q;
		res_load      = 1'b0;
		res_status    = STAT_OK;
		res_element   = '0;
		res_last      = 1'b1;
		dump_start    = 1'b0;
		dump_step     = 1'b0;
		unique case (state_q)
			S_OPS: begin
				s_axis_tready = out_free;
				if (s_fire) begin
					res_load = 1'b1;
					unique case (kind) inside
						K_PUSH_BACK, K_PUSH_FRONT: begin
							if (count_q == FULL_CNT) res_status = STAT_FULL;
							else begin
								ctrl.op = push_low ? CELL_PUSH_LOW : CELL_PUSH_HIGH;
								count_d = count_q + ONE_CNT;
							end
						end
						K_POP_BACK, K_POP_FRONT: begin
							if (count_q == '0) res_status = STAT_EMPTY;
							else begin
								ctrl.op = pop_low ? CELL_POP_LOW : CELL_HOLD;
								count_d = count_q - ONE_CNT;
							end
						end
						K_REVERSE: rev_d = !rev_q;
						K_DUMP: begin
							if (count_q == '0) res_status = STAT_EMPTY;
							else begin
								res_load   = 1'b0;
								dump_start = 1'b1;
							end
						end
						default: res_status = STAT_OK;
					endcase
				end
			end
			S_DUMP: begin
				ctrl.value = rev_q ? tail_c[DEPTH] : cell_data[0];
				if (out_free) begin
					res_load    = 1'b1;
					dump_step   = 1'b1;
					ctrl.op     = rev_q ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
					res_element = ctrl.value;
					res_last    = (dump_left_q == ONE_CNT);
				end
			end
			default: s_axis_tready = 1'b0;
		endcase
		res_count = count_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_OPS;
			count_q     <= ONE_CNT;
			rev_q       <= 1'b0;
			dump_left_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rev_q   <= rev_d;
			if (dump_start) dump_left_q <= count_q;
			else if (dump_step) dump_left_q <= dump_left_q - ONE_CNT;
			if (res_load) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (res_load) begin
			m_status_q  <= res_status;
			m_element_q <= res_element;
			m_occ_q     <= OCC_W'(res_count);
			m_last_q    <= res_last;
		end
	end

	// Row of storage cells
	assign tail_c[0] = '0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_W-1:0] left_n;
		logic [VALUE_W-1:0] right_n;
		if (i == 0) begin : g_first
			assign left_n = '0;
		end else begin : g_mid_l
			assign left_n = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_n = cell_data[i];
		end else begin : g_mid_r
			assign right_n = cell_data[i+1];
		end
		dqr_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.count    (count_q),
			.left     (left_n),
			.right    (right_n),
			.tail_in  (tail_c[i]),
			.data     (cell_data[i]),
			.tail_out (tail_c[i+1])
		);
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - VALUE_W - OCC_W)'(0), m_occ_q, m_element_q};
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tlast  = m_last_q;

endmodule

@@ hw/rtl/dqr_checker.sv @@
// Port-level checks for the double-ended queue with reverse, bound to the top level.
`timescale 1ns / 1ps
module dqr_checker #(
	parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [dqr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [dqr_pkg::STATUS_W-1:0]   m_axis_tuser,
	input logic                           m_axis_tlast
);
	import dqr_pkg::*;

	logic [OCC_W-1:0] occ;
	assign occ = m_axis_tdata[VALUE_W+OCC_W-1:VALUE_W];

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// No request is taken while a dump is still emitting
	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("request taken in the middle of a dump");

	// A refused push reports a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_FULL |-> occ == OCC_W'(DEPTH) && m_axis_tlast)
		else $error("full status with wrong occupancy");

	// A refused pop or dump reports an empty queue and no element
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_EMPTY
			|-> occ == '0 && m_axis_tlast && m_axis_tdata[VALUE_W-1:0] == '0)
		else $error("empty status with stored elements or data");

	// Occupancy never exceeds the capacity
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (DEPTH > 31) || (occ <= OCC_W'(DEPTH)))
		else $error("occupancy above capacity");

endmodule

bind deque_with_reverse dqr_checker #(.DEPTH(DEPTH)) u_dqr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

@@ verif/tb.sv @@
// Self-checking testbench for the double-ended queue with reverse, predicting every result.
`timescale 1ns / 1ps
module tb;
	import dqr_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int SETTLE_CYCLES = 24;
	localparam int CALM_TAIL = 25;
	localparam int MAX_PRINTED = 100;

	// Kinds outside the operation set, which the block answers without touching the queue
	localparam logic [KIND_W-1:0] K_UNUSED_LO = 3'd6;
	localparam logic [KIND_W-1:0] K_UNUSED_HI = 3'd7;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
	} dq_req_t;

	typedef struct {
		status_t            status;
		logic [VALUE_W-1:0] element;
		logic [OCC_W-1:0]   occupancy;
		logic               last;
	} dq_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [KIND_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;
	logic m_axis_tlast;

	deque_with_reverse #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #6 clk = ~clk;

	// Requests still to send and results still owed by the block
	dq_req_t req_q[$];
	dq_res_t owed_q[$];

	// Shadow copy of the queue
	logic [VALUE_W-1:0] shadow_cells[DEPTH];
	int shadow_head = 0;
	int shadow_fill = 1;
	bit shadow_flipped = 1'b0;

	int mismatches = 0;
	int sent_cnt = 0;
	int got_cnt = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		begin
			if (mismatches < MAX_PRINTED)
				$display("%0t: %s mismatch on result %0d: got %0h, want %0h",
					$realtime, what, got_cnt, got, want);
			mismatches++;
		end
	endtask

	// Apply one request to the shadow queue and queue the results it owes
	task automatic deque_apply(input dq_req_t r);
		dq_res_t e;
		bit low_end;
		int slot;
		begin
			e.status = STAT_OK;
			e.element = '0;
			e.last = 1'b1;
			case (r.kind) inside
				K_PUSH_BACK, K_PUSH_FRONT: begin
					low_end = (r.kind == K_PUSH_BACK) ? shadow_flipped : !shadow_flipped;
					if (shadow_fill >= DEPTH) begin
						e.status = STAT_FULL;
					end else begin
						if (low_end) begin
							shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
							shadow_cells[shadow_head] = r.value;
						end else begin
							shadow_cells[(shadow_head + shadow_fill) % DEPTH] = r.value;
						end
						shadow_fill++;
					end
				end
				K_POP_BACK, K_POP_FRONT: begin
					low_end = (r.kind == K_POP_BACK) ? shadow_flipped : !shadow_flipped;
					if (shadow_fill == 0) begin
						e.status = STAT_EMPTY;
					end else begin
						if (low_end)
							shadow_head = (shadow_head + 1) % DEPTH;
						shadow_fill--;
					end
				end
				K_REVERSE: begin
					shadow_flipped = !shadow_flipped;
				end
				K_DUMP: begin
					if (shadow_fill == 0) begin
						e.status = STAT_EMPTY;
					end else begin
						// Emit front to back, one result per element
						for (int i = 0; i < shadow_fill; i++) begin
							slot = shadow_flipped ? (shadow_head + shadow_fill - 1 - i) % DEPTH
								: (shadow_head + i) % DEPTH;
							e.element = shadow_cells[slot];
							e.occupancy = 5'(shadow_fill);
							e.last = (i == shadow_fill - 1);
							owed_q.push_back(e);
						end
						return;
					end
				end
				default: begin
				end
			endcase
			e.occupancy = 5'(shadow_fill);
			owed_q.push_back(e);
		end
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
		dq_req_t r;
		begin
			r.kind = kind;
			r.value = value;
			req_q.push_back(r);
		end
	endtask

	// Request driver with random gaps; tvalid holds until the request is taken
	int send_gap = 0;
	bit send_calm;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				deque_apply(req_q.pop_front());
				sent_cnt++;
			end
			send_calm = (req_q.size() < CALM_TAIL) || ((sent_cnt / 16) % 3 == 2);
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (!send_calm && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(1, 13) - 1;
					s_axis_tvalid <= 1'b0;
				end else if (req_q.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= req_q[0].value;
					s_axis_tuser <= req_q[0].kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each taken result, stall at random and once for a long stretch
	int take_gap = 0;
	int hold_off = 0;
	bit hold_off_done = 1'b0;
	bit take_calm;
	dq_res_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			take_gap = 0;
			hold_off = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_q.size() == 0) begin
					report_mismatch("unexpected", 64'(m_axis_tdata), '0);
				end else begin
					want = owed_q.pop_front();
					if (m_axis_tuser !== want.status)
						report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
					if (m_axis_tdata[31:0] !== want.element)
						report_mismatch("element", 64'(m_axis_tdata[31:0]),
							64'(want.element));
					if (m_axis_tdata[36:32] !== want.occupancy)
						report_mismatch("occupancy", 64'(m_axis_tdata[36:32]),
							64'(want.occupancy));
					if (m_axis_tdata[OUT_DATA_W-1:37] !== '0)
						report_mismatch("padding", 64'(m_axis_tdata[OUT_DATA_W-1:37]), '0);
					if (m_axis_tlast !== want.last)
						report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
				end
				got_cnt++;
			end
			take_calm = (req_q.size() < CALM_TAIL) || ((got_cnt / 20) % 3 == 1);
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 1'b0;
			end else if (!hold_off_done && got_cnt >= 60) begin
				// Back up the block so that it stops taking requests
				hold_off_done = 1'b1;
				hold_off = HOLD_OFF_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				m_axis_tready <= 1'b0;
			end else if (!take_calm && $urandom_range(0, 5) == 0) begin
				take_gap = $urandom_range(1, 13) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no handshake happens for too long
	int quiet = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("[deque_with_reverse] ERROR");
				$finish;
			end
		end
	end

	int rand_cnt;
	int run_len;
	initial begin
		for (int i = 0; i < DEPTH; i++)
			shadow_cells[i] = '0;

		// Directed part: empty queue, extremes, both orientations, unused kinds
		add_req(K_DUMP, $urandom);
		add_req(K_POP_FRONT, $urandom);
		add_req(K_POP_BACK, $urandom);
		add_req(K_POP_FRONT, $urandom);
		add_req(K_DUMP, $urandom);
		add_req(K_REVERSE, $urandom);
		add_req(K_REVERSE, $urandom);
		add_req(K_PUSH_BACK, 32'h7FFF_FFFF);
		add_req(K_PUSH_FRONT, 32'h8000_0000);
		add_req(K_PUSH_BACK, 32'hFFFF_FFFF);
		add_req(K_PUSH_FRONT, 32'h0000_0000);
		add_req(K_DUMP, $urandom);
		add_req(K_REVERSE, $urandom);
		add_req(K_DUMP, $urandom);
		add_req(K_PUSH_BACK, 32'h5555_5555);
		add_req(K_PUSH_FRONT, 32'hAAAA_AAAA);
		add_req(K_DUMP, $urandom);
		add_req(K_POP_FRONT, $urandom);
		add_req(K_POP_BACK, $urandom);
		add_req(K_UNUSED_LO, $urandom);
		add_req(K_UNUSED_HI, $urandom);
		add_req(K_REVERSE, $urandom);
		add_req(K_DUMP, $urandom);

		// Random part: push and pop runs long enough to reach both full and empty, mixed with the rest
		rand_cnt = 0;
		while (rand_cnt < 100) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					run_len = $urandom_range(1, 18);
					for (int i = 0; i < run_len; i++)
						add_req($urandom_range(0, 1) ? K_PUSH_BACK : K_PUSH_FRONT, pick_value());
					rand_cnt += run_len;
				end
				3, 4, 5: begin
					run_len = $urandom_range(1, 18);
					for (int i = 0; i < run_len; i++)
						add_req($urandom_range(0, 1) ? K_POP_BACK : K_POP_FRONT, $urandom);
					rand_cnt += run_len;
				end
				6: begin
					add_req(K_REVERSE, $urandom);
					rand_cnt++;
				end
				7: begin
					add_req(K_DUMP, $urandom);
					rand_cnt++;
				end
				8: begin
					add_req($urandom_range(0, 1) ? K_UNUSED_LO : K_UNUSED_HI, $urandom);
					rand_cnt++;
				end
				default: begin
					add_req(3'($urandom_range(0, 7)), pick_value());
					rand_cnt++;
				end
			endcase
		end
		add_req(K_DUMP, $urandom);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every request taken, every result seen, then let the block settle
		while (req_q.size() != 0 || s_axis_tvalid || owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_q.size() == 0)
			$display("[deque_with_reverse] OK");
		else
			$display("[deque_with_reverse] ERROR");
		$finish;
	end

endmodule
